// ===== hdl/buffer_free_list_allocator_macros.svh =====
// Assertion macros used by the checker file.
// Every macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef BUFFER_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BUFFER_FREE_LIST_ALLOCATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define BFLA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define BFLA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/bfla_pkg.sv =====
`default_nettype none

package bfla_pkg;

	// Field widths.
	localparam int HANDLE_W = 8;
	localparam int CNT_W    = 9;
	localparam int STATUS_W = 2;

	// Default number of stack slots.
	localparam int POOL_DEPTH_DEF = 256;

	// Pool size that reset establishes, before it is limited to the stack depth.
	localparam int POOL_RST = 256;

	// Register port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [ADDR_W-1:0] REG_POOL_SIZE = 3'd0;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_FULL    = 2'd2,
		ST_SKIPPED = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t             req_type;
		logic [HANDLE_W-1:0]   free_handle;
		logic                  batch_last;
	} req_t;

	typedef struct packed {
		status_t               status;
		logic [HANDLE_W-1:0]   alloc_handle;
		logic [CNT_W-1:0]      busy_count;
		logic [CNT_W-1:0]      busy_peak;
	} rsp_t;

endpackage

`default_nettype wire

// ===== hdl/bfla_stream_if.sv =====
`default_nettype none

// Valid/ready channel carrying one payload per transaction.
interface bfla_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bfla_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/buffer_free_list_allocator.sv =====
// Channel  Dir  Payload                                        Transaction when
// req      in   req_type, free_handle, batch_last              req.valid & req.ready
// rsp      out  status, alloc_handle, busy_count, busy_peak    rsp.valid & rsp.ready
// apb      in   pool_size at byte address 0                    psel & penable & pwrite
//
// One request is taken per cycle while rsp is not stalled; its result passes through stage one and the output register.
// A successful request does a single read (allocate) or write (free) of the stack RAM; a failed one does neither.
// Reset or a pool_size write restarts the pool at once; there is no clearing pass.
// A stalled rsp channel holds the result and backs up through one stage to req.ready.
`default_nettype none

module buffer_free_list_allocator #(
	parameter int POOL_DEPTH = bfla_pkg::POOL_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [bfla_pkg::ADDR_W-1:0] paddr,
	input  wire logic [bfla_pkg::DATA_W-1:0] pwdata,
	output logic      [bfla_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	bfla_stream_if.sink                     req,
	bfla_stream_if.source                   rsp
);

	import bfla_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);
	localparam int TW = (AW > CNT_W) ? AW : CNT_W;
	localparam int RST_SIZE = (POOL_RST < POOL_DEPTH) ? POOL_RST : POOL_DEPTH;

	// Pool state.
	logic [CNT_W-1:0] pool_q;
	logic [CNT_W-1:0] busy_q;
	logic [CNT_W-1:0] peak_q;
	logic             batch_failed_q;

	// Decision for the request at the port.
	status_t             st_c;
	logic [HANDLE_W-1:0] hnd_c;
	logic [CNT_W-1:0]    busy_c;
	logic [CNT_W-1:0]    peak_c;
	logic [CNT_W-1:0]    top_c;
	logic [CNT_W-1:0]    top_dec_c;
	logic                batch_c;
	logic                use_ram_c;
	logic                rd_c;
	logic                wr_c;

	// Pipeline.
	logic                vld_s1;
	status_t             status_s1;
	logic [HANDLE_W-1:0] hnd_s1;
	logic                use_ram_s1;
	logic [CNT_W-1:0]    busy_s1;
	logic [CNT_W-1:0]    peak_s1;
	logic                vld_s2;
	rsp_t                rsp_s2;

	logic                req_fire;
	logic                s1_move;
	logic                cfg_wr;
	logic [CNT_W-1:0]    cfg_size;
	logic [TW-1:0]       rd_ext;
	logic [TW-1:0]       wr_ext;
	logic [HANDLE_W-1:0] ram_rd_data;

	// Register port; registers are decoded by word address.
	assign pready = 1'b1;
	assign prdata = DATA_W'(pool_q);
	assign cfg_wr = psel && penable && pwrite &&
		(paddr[ADDR_W-1:2] == REG_POOL_SIZE[ADDR_W-1:2]);

	// A written size of zero becomes one; a size beyond the stack becomes its depth.
	always_comb begin
		cfg_size = pwdata[CNT_W-1:0];
		if (cfg_size == '0) begin
			cfg_size = CNT_W'(1);
		end else if (32'(cfg_size) > 32'(POOL_DEPTH)) begin
			cfg_size = CNT_W'(POOL_DEPTH);
		end
	end

	// Handshake: the first stage frees up whenever the output register can take it.
	assign s1_move   = vld_s1 && (!vld_s2 || rsp.ready);
	assign req.ready = !vld_s1 || s1_move;
	assign req_fire  = req.valid && req.ready;

	// Request decision. The stack top is pool_q - busy_q. A slot below
	// pool_q - peak_q has never been written since initialization and still
	// holds its own index, so the RAM is read only when busy_q < peak_q.
	always_comb begin
		st_c      = ST_OK;
		hnd_c     = '0;
		busy_c    = busy_q;
		peak_c    = peak_q;
		batch_c   = batch_failed_q;
		use_ram_c = 1'b0;
		rd_c      = 1'b0;
		wr_c      = 1'b0;
		top_c     = pool_q - busy_q;
		top_dec_c = top_c - CNT_W'(1);
		if (req.data.req_type == REQ_ALLOC) begin
			batch_c = 1'b0;
			if (busy_q >= pool_q) begin
				st_c = ST_EMPTY;
			end else begin
				rd_c      = 1'b1;
				use_ram_c = busy_q < peak_q;
				hnd_c     = top_dec_c[HANDLE_W-1:0];
				busy_c    = busy_q + CNT_W'(1);
				if (busy_c > peak_q) begin
					peak_c = busy_c;
				end
			end
		end else if (batch_failed_q) begin
			st_c    = ST_SKIPPED;
			batch_c = !req.data.batch_last;
		end else if (busy_q == '0) begin
			st_c    = ST_FULL;
			batch_c = !req.data.batch_last;
		end else begin
			wr_c   = 1'b1;
			busy_c = busy_q - CNT_W'(1);
		end
	end

	assign rd_ext = TW'(top_dec_c);
	assign wr_ext = TW'(top_c);

	// Free stack storage.
	bfla_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (POOL_DEPTH)
	) u_stack (
		.clk     (clk),
		.wr_en   (req_fire && wr_c),
		.wr_addr (wr_ext[AW-1:0]),
		.wr_data (req.data.free_handle),
		.rd_en   (req_fire && rd_c),
		.rd_addr (rd_ext[AW-1:0]),
		.rd_data (ram_rd_data)
	);

	// Pool state update; a pool_size write reinitializes the pool.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_q         <= CNT_W'(RST_SIZE);
			busy_q         <= '0;
			peak_q         <= '0;
			batch_failed_q <= 1'b0;
		end else if (cfg_wr) begin
			pool_q         <= cfg_size;
			busy_q         <= '0;
			peak_q         <= '0;
			batch_failed_q <= 1'b0;
		end else if (req_fire) begin
			busy_q         <= busy_c;
			peak_q         <= peak_c;
			batch_failed_q <= batch_c;
		end
	end

	// Stage valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (req_fire) begin
				vld_s1 <= 1'b1;
			end else if (s1_move) begin
				vld_s1 <= 1'b0;
			end
			if (s1_move) begin
				vld_s2 <= 1'b1;
			end else if (rsp.ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Stage payloads; the RAM read data lands together with stage one.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_s1  <= st_c;
			hnd_s1     <= hnd_c;
			use_ram_s1 <= use_ram_c;
			busy_s1    <= busy_c;
			peak_s1    <= peak_c;
		end
		if (s1_move) begin
			rsp_s2.status       <= status_s1;
			rsp_s2.alloc_handle <= use_ram_s1 ? ram_rd_data : hnd_s1;
			rsp_s2.busy_count   <= busy_s1;
			rsp_s2.busy_peak    <= peak_s1;
		end
	end

	assign rsp.valid = vld_s2;
	assign rsp.data  = rsp_s2;

endmodule

`default_nettype wire

// ===== hdl/bfla_checker.sv =====
`default_nettype none

`include "buffer_free_list_allocator_macros.svh"

module bfla_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          req_valid,
	input wire logic                          req_ready,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire bfla_pkg::status_t             status,
	input wire logic [bfla_pkg::HANDLE_W-1:0] alloc_handle,
	input wire logic [bfla_pkg::CNT_W-1:0]    busy_count,
	input wire logic [bfla_pkg::CNT_W-1:0]    busy_peak
);

	import bfla_pkg::*;

	// A result that is not taken stays offered.
	`BFLA_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")

	// A request taken while the output is empty shows a result once it has passed stage one and the output register.
	`BFLA_ASSERT_IMP(a_latency, req_valid && req_ready && !rsp_valid, ##2 rsp_valid, "result late")

	// The busy count never exceeds the high-water mark.
	`BFLA_ASSERT_IMP(a_peak, rsp_valid, busy_count <= busy_peak, "busy count above peak")

	// Only a successful allocation gives out a handle other than zero.
	`BFLA_ASSERT_IMP(a_handle, rsp_valid && status != ST_OK, alloc_handle == '0, "stray handle")

endmodule

bind buffer_free_list_allocator bfla_checker u_bfla_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.status       (rsp.data.status),
	.alloc_handle (rsp.data.alloc_handle),
	.busy_count   (rsp.data.busy_count),
	.busy_peak    (rsp.data.busy_peak)
);

`default_nettype wire
